// File: hw/rtl/sktc_pkg.sv
`timescale 1ns / 1ps

package sktc_pkg;

  localparam int MAX_TOKEN_LEN = 64;
  localparam int LEN_W = 7;
  localparam int CLASS_W = 5;
  localparam int PREFIX_DEPTH = 6;
  localparam int NUM_WORDS = 18;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 5'd18;

  typedef logic [8*PREFIX_DEPTH-1:0] prefix_t;

  typedef struct packed {
    logic [CLASS_W-1:0] token_class;
    logic [LEN_W-1:0]   token_length;
    logic               overflowed;
    logic               ends_string;
  } result_t;

  // first byte in the top bits, padded with zero bytes
  function automatic prefix_t word_text(input logic [CLASS_W-1:0] idx);
    prefix_t t;
    case (idx)
      5'd0:    t = "select";
      5'd1:    t = {"from", 16'h0};
      5'd2:    t = {"where", 8'h0};
      5'd3:    t = {"and", 24'h0};
      5'd4:    t = {"or", 32'h0};
      5'd5:    t = {"is", 32'h0};
      5'd6:    t = {"in", 32'h0};
      5'd7:    t = {"not", 24'h0};
      5'd8:    t = {"null", 16'h0};
      5'd9:    t = {"=", 40'h0};
      5'd10:   t = {"!=", 32'h0};
      5'd11:   t = {">", 40'h0};
      5'd12:   t = {"<", 40'h0};
      5'd13:   t = {">=", 32'h0};
      5'd14:   t = {"<=", 32'h0};
      5'd15:   t = {",", 40'h0};
      5'd16:   t = {";", 40'h0};
      5'd17:   t = {"*", 40'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] word_len(input logic [CLASS_W-1:0] idx);
    logic [LEN_W-1:0] n;
    case (idx)
      5'd0:                      n = 7'd6;
      5'd2:                      n = 7'd5;
      5'd1, 5'd8:                n = 7'd4;
      5'd3, 5'd7:                n = 7'd3;
      5'd4, 5'd5, 5'd6, 5'd10,
      5'd13, 5'd14:              n = 7'd2;
      5'd9, 5'd11, 5'd12, 5'd15,
      5'd16, 5'd17:              n = 7'd1;
      default:                   n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/sktc_token_unit.sv
`timescale 1ns / 1ps

module sktc_token_unit import sktc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] char_byte,
  output logic       result_valid,
  output result_t    result
);

  logic [7:0]       prefix [PREFIX_DEPTH];
  logic [LEN_W-1:0] count;
  logic             overflow;

  logic             is_sep;
  prefix_t          prefix_packed;
  logic [CLASS_W-1:0] match_class;

  assign is_sep = (char_byte == SPACE_CHAR) || (char_byte == NUL_CHAR);

  always_comb begin
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      prefix_packed[8*(PREFIX_DEPTH-1-i) +: 8] = prefix[i];
    end
  end

  // bytes past the count are held at zero, so a full-width compare suffices
  always_comb begin
    match_class = CLASS_UNKNOWN;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (count == word_len(CLASS_W'(i)) && prefix_packed == word_text(CLASS_W'(i))) begin
        match_class = CLASS_W'(i);
      end
    end
  end

  assign result_valid = advance && is_sep && (count != '0);

  always_comb begin
    result.token_class  = overflow ? CLASS_UNKNOWN : match_class;
    result.token_length = count;
    result.overflowed   = overflow;
    result.ends_string  = (char_byte == NUL_CHAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      for (int i = 0; i < PREFIX_DEPTH; i++) begin
        prefix[i] <= '0;
      end
    end else if (advance) begin
      if (is_sep) begin
        count    <= '0;
        overflow <= 1'b0;
        for (int i = 0; i < PREFIX_DEPTH; i++) begin
          prefix[i] <= '0;
        end
      end else if (count >= LEN_W'(MAX_TOKEN_LEN)) begin
        overflow <= 1'b1;
      end else begin
        if (count < LEN_W'(PREFIX_DEPTH)) begin
          prefix[count[2:0]] <= char_byte;
        end
        count <= count + 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(MAX_TOKEN_LEN))
    else $error("token count beyond buffer size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (count == LEN_W'(MAX_TOKEN_LEN)))
    else $error("overflow set with buffer not full");

  a_sep_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && is_sep) |=> (count == '0 && !overflow))
    else $error("token state not cleared after separator");

endmodule

// File: hw/rtl/sktc_out_buf.sv
`timescale 1ns / 1ps

module sktc_out_buf import sktc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main;
  result_t skid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        main       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!main_valid || out_ready) begin
        main       <= in_data;
        main_valid <= 1'b1;
      end else begin
        skid       <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      main_valid <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty output register");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !skid_valid)
    else $error("result offered while buffer full");

endmodule

// File: hw/rtl/sql_keyword_token_classifier_core.sv
`timescale 1ns / 1ps

// byte-stream token classifier: one statement byte per request on the slave side, space
// separates tokens, NUL ends the string; each non-empty token gives one result request
// carrying its class (9 keywords, 9 operator or punctuation tokens, or unknown), its
// length saturated at 64, an overflow flag and, on tlast, whether NUL ended it. one byte
// is taken every cycle while the output buffer has room: the byte is registered, matched
// in a single pass against the 18-entry word table via a six-byte prefix buffer, and the
// result lands in a two-entry output buffer; the byte register and the output register
// lie between the byte that ends the token and its result. the output buffer keeps its
// ready registered and stalls the input only once both of its entries are held.

module sql_keyword_token_classifier_core import sktc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // token_class, token_length, overflowed, zero pad
  output logic        m_axis_tlast    // ends_string
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       buf_ready;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance       = in_valid && buf_ready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
      in_byte  <= s_axis_tdata;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  sktc_token_unit u_token (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .char_byte    (in_byte),
    .result_valid (res_valid),
    .result       (res)
  );

  sktc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (buf_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.overflowed, out_res.token_length,
                         out_res.token_class};
  assign m_axis_tlast = out_res.ends_string;

endmodule

// File: tb/sv/tb_sql_keyword_token_classifier_core.sv
`timescale 1ns / 1ps

module tb_sql_keyword_token_classifier_core;
  import sktc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int BYTE_TARGET = 1600;

  typedef enum logic [CLASS_W-1:0] {
    CL_SELECT, CL_FROM, CL_WHERE, CL_AND, CL_OR, CL_IS, CL_IN, CL_NOT, CL_NULL,
    CL_EQ, CL_NE, CL_GT, CL_LT, CL_GE, CL_LE, CL_COMMA, CL_SEMI, CL_STAR,
    CL_UNKNOWN
  } token_class_e;

  class token_tracker;
    string       words [NUM_WORDS];
    logic [7:0]  head [PREFIX_DEPTH];
    int unsigned held;
    bit          spilled;
    result_t     expected_tokens [$];
    int unsigned errors;

    function new();
      words = '{"select", "from", "where", "and", "or", "is", "in", "not", "null",
                "=", "!=", ">", "<", ">=", "<=", ",", ";", "*"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (head[i]) head[i] = '0;
      held = 0;
      spilled = 0;
    endfunction

    function token_class_e classify_token();
      string w;
      bit    hit;
      if (spilled) return CL_UNKNOWN;
      for (int k = 0; k < NUM_WORDS; k++) begin
        w = words[k];
        if (held == w.len()) begin
          hit = 1;
          for (int j = 0; j < w.len(); j++)
            if (head[j] != w[j]) hit = 0;
          if (hit) return token_class_e'(k);
        end
      end
      return CL_UNKNOWN;
    endfunction

    function void note_byte(logic [7:0] c);
      result_t r;
      if (c == SPACE_CHAR || c == NUL_CHAR) begin
        if (held != 0) begin
          r.token_class = classify_token();
          r.token_length = LEN_W'(held);
          r.overflowed = spilled;
          r.ends_string = (c == NUL_CHAR);
          expected_tokens.push_back(r);
          clear();
        end
      end else if (held >= MAX_TOKEN_LEN) begin
        spilled = 1;
      end else begin
        if (held < PREFIX_DEPTH) head[held] = c;
        held++;
      end
    endfunction

    function void check_result(logic [15:0] data, logic last);
      result_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result request: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (data[4:0] != want.token_class) begin
        $error("token_class: expected %0d, actual %0d", want.token_class, data[4:0]);
        errors++;
      end
      if (data[11:5] != want.token_length) begin
        $error("token_length: expected %0d, actual %0d", want.token_length, data[11:5]);
        errors++;
      end
      if (data[12] != want.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", want.overflowed, data[12]);
        errors++;
      end
      if (last != want.ends_string) begin
        $error("ends_string: expected %0b, actual %0b", want.ends_string, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  token_tracker sb;
  logic [7:0]   tok_bytes [$];
  int unsigned  sent_bytes;
  int unsigned  cycles;
  int unsigned  stall_left;
  bit           in_calm;
  bit           rd_calm;

  sql_keyword_token_classifier_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short pauses, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] any_token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == SPACE_CHAR);
    return b;
  endfunction

  task send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 149) == 0) in_calm = ~in_calm;
    gap = (in_calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  task load_word(input string s);
    tok_bytes.delete();
    for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
  endtask

  task load_random(input int n);
    tok_bytes.delete();
    repeat (n) tok_bytes.push_back(any_token_byte());
  endtask

  task emit_token();
    foreach (tok_bytes[i]) send_byte(tok_bytes[i]);
  endtask

  task mutate_token();
    int pos;
    case ($urandom_range(0, 3))
      0: begin
        pos = $urandom_range(0, tok_bytes.size() - 1);
        tok_bytes[pos] = tok_bytes[pos] ^ 8'h20;
      end
      1: tok_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
      2: begin
        if (tok_bytes.size() > 1) void'(tok_bytes.pop_back());
        else tok_bytes.push_back("=");
      end
      default: tok_bytes.push_front(any_token_byte());
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) rd_calm <= ~rd_calm;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rd_calm || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= gap_len() - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sql_keyword_token_classifier_core: errors");
      $finish;
    end
  end

  initial begin
    int pick;
    int sep;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sent_bytes = 0;
    in_calm = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // leading and repeated spaces, nul after a space, odd bytes, nul ending a token
    send_byte(SPACE_CHAR);
    send_byte(SPACE_CHAR);
    load_word("select");
    emit_token();
    send_byte(SPACE_CHAR);
    send_byte(SPACE_CHAR);
    load_word("<=");
    emit_token();
    send_byte(SPACE_CHAR);
    send_byte(NUL_CHAR);
    tok_bytes = '{8'h09, 8'hff, 8'h80, 8'h7f, 8'h01};
    emit_token();
    send_byte(NUL_CHAR);
    load_word("*");
    emit_token();
    send_byte(NUL_CHAR);
    // full buffer, then one byte beyond it
    load_random(MAX_TOKEN_LEN);
    emit_token();
    send_byte(SPACE_CHAR);
    load_random(MAX_TOKEN_LEN + 1);
    emit_token();
    send_byte(NUL_CHAR);

    while (sent_bytes < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        load_word(sb.words[$urandom_range(0, NUM_WORDS - 1)]);
      end else if (pick < 60) begin
        load_word(sb.words[$urandom_range(0, NUM_WORDS - 1)]);
        mutate_token();
      end else if (pick < 96) begin
        load_random($urandom_range(1, 8));
      end else begin
        load_random($urandom_range(MAX_TOKEN_LEN - 2, MAX_TOKEN_LEN + 4));
      end
      emit_token();
      sep = $urandom_range(0, 99);
      if (sep < 72) begin
        send_byte(SPACE_CHAR);
      end else if (sep < 85) begin
        send_byte(NUL_CHAR);
      end else begin
        repeat ($urandom_range(2, 4))
          send_byte($urandom_range(0, 1) ? SPACE_CHAR : NUL_CHAR);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_sql_keyword_token_classifier_core: clean");
    end else begin
      $display("tb_sql_keyword_token_classifier_core: errors");
    end
    $finish;
  end

endmodule
